// ----- sv/ppt_pkg.sv -----
// Shared types and constants for the point to path proximity test.
// Used by the top level, the segment distance pipeline and the testbench.
package ppt_pkg;

   localparam int MAX_WAYPOINTS = 256;
   localparam int COORD_BITS    = 24;
   localparam int PW_BITS       = 15;
   localparam int STRIDE_BITS   = 5;
   localparam int SEG_BITS      = 8;

   localparam int ADDR_BITS = $clog2(MAX_WAYPOINTS);
   localparam int CNT_BITS  = $clog2(MAX_WAYPOINTS + 1);
   localparam int WALK_BITS = $clog2(MAX_WAYPOINTS + (1 << STRIDE_BITS));
   localparam int RAM_WIDTH = 2 * COORD_BITS;

   localparam int D_BITS   = COORD_BITS + 1;
   localparam int P_BITS   = 2 * D_BITS;
   localparam int S_BITS   = P_BITS + 1;
   localparam int LO_BITS  = D_BITS;
   localparam int HI_BITS  = S_BITS - LO_BITS;
   localparam int HL_BITS  = HI_BITS + LO_BITS + 1;
   localparam int W2_BITS  = 2 * PW_BITS;
   localparam int WAB_BITS = W2_BITS + S_BITS;
   localparam int X_BITS   = 2 * S_BITS + 1;

   localparam int REQ_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = ((1 + SEG_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = PW_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATH_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRIDE     = 1'd1;

   localparam logic [PW_BITS-1:0]     PATH_WIDTH_RESET = 15'd512;
   localparam logic [STRIDE_BITS-1:0] STRIDE_RESET     = 5'd4;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEST   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                valid;
      logic [SEG_BITS-1:0] seg_num;
   } seg_in_type;

   typedef struct packed {
      logic                valid;
      logic                busy;
      logic                hit;
      logic [SEG_BITS-1:0] seg_num;
   } seg_out_type;

endpackage

// ----- sv/ppt_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Stands alone; no package needed.
module ppt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ppt_seg_pipe.sv -----
// Six stage pipeline that decides whether a point lies within the path width of one segment.
// Depends on ppt_pkg; takes one segment per cycle and never stalls.
module ppt_seg_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          flush,
   input  ppt_pkg::seg_in_type           seg_in,
   input  ppt_pkg::coord_type            ax,
   input  ppt_pkg::coord_type            ay,
   input  ppt_pkg::coord_type            bx,
   input  ppt_pkg::coord_type            by,
   input  ppt_pkg::coord_type            px,
   input  ppt_pkg::coord_type            py,
   input  logic [ppt_pkg::W2_BITS-1:0]   w2,
   output ppt_pkg::seg_out_type          seg_out
);
   import ppt_pkg::*;

   logic vd_ff, vp_ff, vs_ff, vm_ff, vc_ff, vh_ff;
   logic [SEG_BITS-1:0] segd_ff, segp_ff, segs_ff, segm_ff, segc_ff, segh_ff;

   logic signed [D_BITS-1:0] abx_ff, aby_ff, apx_ff, apy_ff, bpx_ff, bpy_ff;

   logic signed [P_BITS-1:0] abxx_ff, abyy_ff, dotx_ff, doty_ff, cra_ff, crb_ff;
   logic signed [P_BITS-1:0] paxx_ff, payy_ff, pbxx_ff, pbyy_ff;

   logic [S_BITS-1:0]        ab2_ff, da2_ff, db2_ff;
   logic signed [S_BITS-1:0] dot_ff, cross_ff;

   logic signed [HI_BITS-1:0] ch;
   logic [LO_BITS-1:0]        cl;
   logic zero_ff, rega_ff, regb_ff, na_ff, nb_ff;
   logic signed [2*HI_BITS-1:0] hh_ff;
   logic signed [HL_BITS-1:0]   hl_ff;
   logic [2*LO_BITS-1:0]        ll_ff;
   logic [W2_BITS+HI_BITS-1:0]  wh_ff;
   logic [W2_BITS+LO_BITS-1:0]  wl_ff;

   logic [X_BITS-1:0]   cross2_ff;
   logic [WAB_BITS-1:0] wab_ff;
   logic mid_ff, endhit_ff;

   logic hit_ff;

   assign ch = cross_ff[S_BITS-1:LO_BITS];
   assign cl = cross_ff[LO_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         vd_ff <= 1'b0;
         vp_ff <= 1'b0;
         vs_ff <= 1'b0;
         vm_ff <= 1'b0;
         vc_ff <= 1'b0;
         vh_ff <= 1'b0;
      end else begin
         vd_ff <= seg_in.valid;
         vp_ff <= vd_ff;
         vs_ff <= vp_ff;
         vm_ff <= vs_ff;
         vc_ff <= vm_ff;
         vh_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      segd_ff <= seg_in.seg_num;
      abx_ff  <= {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
      aby_ff  <= {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
      apx_ff  <= {px[COORD_BITS-1], px} - {ax[COORD_BITS-1], ax};
      apy_ff  <= {py[COORD_BITS-1], py} - {ay[COORD_BITS-1], ay};
      bpx_ff  <= {px[COORD_BITS-1], px} - {bx[COORD_BITS-1], bx};
      bpy_ff  <= {py[COORD_BITS-1], py} - {by[COORD_BITS-1], by};

      segp_ff <= segd_ff;
      abxx_ff <= abx_ff * abx_ff;
      abyy_ff <= aby_ff * aby_ff;
      dotx_ff <= apx_ff * abx_ff;
      doty_ff <= apy_ff * aby_ff;
      cra_ff  <= apx_ff * aby_ff;
      crb_ff  <= apy_ff * abx_ff;
      paxx_ff <= apx_ff * apx_ff;
      payy_ff <= apy_ff * apy_ff;
      pbxx_ff <= bpx_ff * bpx_ff;
      pbyy_ff <= bpy_ff * bpy_ff;

      segs_ff  <= segp_ff;
      ab2_ff   <= {abxx_ff[P_BITS-1], abxx_ff} + {abyy_ff[P_BITS-1], abyy_ff};
      dot_ff   <= {dotx_ff[P_BITS-1], dotx_ff} + {doty_ff[P_BITS-1], doty_ff};
      cross_ff <= {cra_ff[P_BITS-1], cra_ff} - {crb_ff[P_BITS-1], crb_ff};
      da2_ff   <= {paxx_ff[P_BITS-1], paxx_ff} + {payy_ff[P_BITS-1], payy_ff};
      db2_ff   <= {pbxx_ff[P_BITS-1], pbxx_ff} + {pbyy_ff[P_BITS-1], pbyy_ff};

      segm_ff <= segs_ff;
      zero_ff <= (ab2_ff == '0);
      rega_ff <= dot_ff[S_BITS-1];
      regb_ff <= ($signed(ab2_ff) < dot_ff);
      na_ff   <= (da2_ff < S_BITS'(w2));
      nb_ff   <= (db2_ff < S_BITS'(w2));
      hh_ff   <= ch * ch;
      hl_ff   <= ch * $signed({1'b0, cl});
      ll_ff   <= cl * cl;
      wh_ff   <= w2 * ab2_ff[S_BITS-1:LO_BITS];
      wl_ff   <= w2 * ab2_ff[LO_BITS-1:0];

      segc_ff   <= segm_ff;
      cross2_ff <= (X_BITS'(hh_ff) << (2 * LO_BITS)) + (X_BITS'(hl_ff) << (LO_BITS + 1))
                   + X_BITS'(ll_ff);
      wab_ff    <= (WAB_BITS'(wh_ff) << LO_BITS) + WAB_BITS'(wl_ff);
      mid_ff    <= !zero_ff && !rega_ff && !regb_ff;
      endhit_ff <= !zero_ff && (rega_ff ? na_ff : (regb_ff && nb_ff));

      segh_ff <= segc_ff;
      hit_ff  <= endhit_ff || (mid_ff && (cross2_ff < X_BITS'(wab_ff)));
   end

   always_comb begin
      seg_out.valid   = vh_ff;
      seg_out.busy    = vd_ff || vp_ff || vs_ff || vm_ff || vc_ff || vh_ff;
      seg_out.hit     = hit_ff;
      seg_out.seg_num = segh_ff;
   end

endmodule

// ----- sv/point_path_proximity_test.sv -----
// Top level of the point to path proximity test: request decode, waypoint RAM and walk control.
// Depends on ppt_pkg, ppt_ram and ppt_seg_pipe.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tuser: operation; tdata: pos_x, pos_y
//   rsp      out        rsp_tvalid/tready    tdata: hit, segment_number
//   csr      in         csr_wen              csr_index, csr_wdata
//
// Clear and append requests are handled in the idle state. A test request reads waypoint 0
// and every stride-th one below the count, one waypoint per cycle, into a segment pipeline
// six stages deep, and a hit on any segment ends the walk before the rest are read.
// Reset is synchronous and needs no clearing pass.
// A finished result waits in the output register while the next request is taken; a second
// finished result holds the request side until the first one is accepted.
module point_path_proximity_test (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y
   input  logic [ppt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // operation
   input  logic [ppt_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit, segment_number, zero padding
   output logic [ppt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_wen,
   input  logic [ppt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ppt_pkg::*;

   state_type state_ff, state_in;

   logic [PW_BITS-1:0]     pw_ff;
   logic [STRIDE_BITS-1:0] stride_ff, stride_eff;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [WALK_BITS-1:0]   b_ff, b_in;
   logic [SEG_BITS-1:0]    seg_cnt_ff, seg_cnt_in;
   logic [W2_BITS-1:0]     w2_ff;
   coord_type              px_ff, py_ff, ax_ff, ay_ff;
   logic                   v0_ff, f0_ff;

   logic                res_hit_ff, res_hit_in;
   logic [SEG_BITS-1:0] res_seg_ff, res_seg_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_load;
   logic                rsp_hit_ff;
   logic [SEG_BITS-1:0] rsp_seg_ff;

   logic                 accept, start_test, walking, seg_go;
   op_type               op;
   logic                 wr_en, rd_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [RAM_WIDTH-1:0] wr_data, rd_data;
   coord_type            rd_x, rd_y;

   seg_in_type  pipe_in;
   seg_out_type pipe_out;

   assign op         = op_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start_test = accept && (op == OP_TEST);
   assign walking    = (state_ff == ST_WALK);
   assign stride_eff = (stride_ff == '0) ? STRIDE_BITS'(1) : stride_ff;

   assign wr_en   = accept && (op == OP_APPEND) && (count_ff < CNT_BITS'(MAX_WAYPOINTS));
   assign wr_addr = count_ff[ADDR_BITS-1:0];
   assign wr_data = req_tdata[RAM_WIDTH-1:0];
   assign rd_en   = walking && (b_ff < WALK_BITS'(count_ff));
   assign rd_addr = b_ff[ADDR_BITS-1:0];
   assign rd_x    = rd_data[COORD_BITS-1:0];
   assign rd_y    = rd_data[RAM_WIDTH-1:COORD_BITS];

   assign seg_go          = walking && v0_ff && !f0_ff;
   assign pipe_in.valid   = seg_go;
   assign pipe_in.seg_num = seg_cnt_ff;

   ppt_ram #(
      .WIDTH (RAM_WIDTH),
      .DEPTH (MAX_WAYPOINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ppt_seg_pipe u_pipe (
      .clock   (clock),
      .reset   (reset),
      .flush   (!walking),
      .seg_in  (pipe_in),
      .ax      (ax_ff),
      .ay      (ay_ff),
      .bx      (rd_x),
      .by      (rd_y),
      .px      (px_ff),
      .py      (py_ff),
      .w2      (w2_ff),
      .seg_out (pipe_out)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      b_in       = b_ff;
      seg_cnt_in = seg_cnt_ff;
      res_hit_in = res_hit_ff;
      res_seg_in = res_seg_ff;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_TEST: begin
                     b_in       = '0;
                     seg_cnt_in = '0;
                     state_in   = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               b_in = b_ff + WALK_BITS'(stride_eff);
            end
            if (seg_go) begin
               seg_cnt_in = seg_cnt_ff + SEG_BITS'(1);
            end
            if (pipe_out.valid && pipe_out.hit) begin
               res_hit_in = 1'b1;
               res_seg_in = pipe_out.seg_num;
               state_in   = ST_DONE;
            end else if (!rd_en && !v0_ff && !pipe_out.busy) begin
               res_hit_in = 1'b0;
               res_seg_in = '0;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff        <= PATH_WIDTH_RESET;
         stride_ff    <= STRIDE_RESET;
         count_ff     <= '0;
         v0_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_PATH_WIDTH: pw_ff     <= csr_wdata;
               CSR_STRIDE:     stride_ff <= csr_wdata[STRIDE_BITS-1:0];
               default: begin
               end
            endcase
         end
         count_ff     <= count_in;
         v0_ff        <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      seg_cnt_ff <= seg_cnt_in;
      res_hit_ff <= res_hit_in;
      res_seg_ff <= res_seg_in;
      f0_ff      <= (b_ff == '0);
      if (start_test) begin
         px_ff <= req_tdata[COORD_BITS-1:0];
         py_ff <= req_tdata[RAM_WIDTH-1:COORD_BITS];
         w2_ff <= pw_ff * pw_ff;
      end
      if (walking && v0_ff) begin
         ax_ff <= rd_x;
         ay_ff <= rd_y;
      end
      if (rsp_load) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_seg_ff <= res_seg_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_seg_ff, rsp_hit_ff});

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_WAYPOINTS))
      else $error("waypoint count exceeds capacity");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("waypoint RAM written and read in one cycle");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!v0_ff && !pipe_out.busy))
      else $error("segment work still in flight while taking requests");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_seg_ff == '0))
      else $error("segment number not zero on a miss");
`endif

endmodule

// ----- dv/tb_point_path_proximity_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for point_path_proximity_test: builds waypoint paths, sends test
// points and compares every hit result against an exact squared-distance predictor.
// Depends on ppt_pkg and the point_path_proximity_test RTL only.
module tb_point_path_proximity_test;

   import ppt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_TARGET = 1900;
   localparam longint COORD_MAX = 64'sd8388607;
   localparam longint COORD_MIN = -64'sd8388608;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic                hit;
      logic [SEG_BITS-1:0] seg_num;
   } prox_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [REQ_USER_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   prox_result_type expected_results[$];
   longint path_x[MAX_WAYPOINTS];
   longint path_y[MAX_WAYPOINTS];
   int path_len = 0;
   int cur_width = PATH_WIDTH_RESET;
   int cur_stride = STRIDE_RESET;

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int hits_seen = 0;
   int settings_written = 0;
   bit gaps_on = 1'b1;
   int stall_requests = 0;
   int stall_served = 0;
   int rsp_left = 0;
   int quiet_cycles = 0;

   point_path_proximity_test DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic wide_type norm2(wide_type a, wide_type b);
      return a * a + b * b;
   endfunction

   // Exact point to segment test: endpoint distance outside the span, else cross product.
   function automatic bit within_band(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py, wide_type w2);
      wide_type abx, aby, apx, apy, ab2, dot, crs;
      abx = bx - ax;
      aby = by - ay;
      apx = px - ax;
      apy = py - ay;
      ab2 = norm2(abx, aby);
      if (ab2 == 0) return 1'b0;
      dot = apx * abx + apy * aby;
      if (dot < 0) return norm2(apx, apy) < w2;
      if (ab2 < dot) return norm2(px - bx, py - by) < w2;
      crs = apx * aby - apy * abx;
      return crs * crs < w2 * ab2;
   endfunction

   function automatic prox_result_type predict_proximity(longint px, longint py);
      prox_result_type res;
      int walk, a, b;
      logic [SEG_BITS-1:0] segn;
      wide_type w2;
      res.hit = 1'b0;
      res.seg_num = '0;
      walk = (cur_stride == 0) ? 1 : cur_stride;
      w2 = wide_type'(cur_width) * wide_type'(cur_width);
      a = 0;
      segn = '0;
      for (b = walk; b < path_len; b += walk) begin
         if (within_band(path_x[a], path_y[a], path_x[b], path_y[b], px, py, w2)) begin
            res.hit = 1'b1;
            res.seg_num = segn;
            return res;
         end
         a = b;
         segn++;
      end
      return res;
   endfunction

   function automatic void apply_request(logic [1:0] op, longint x, longint y);
      longint xs, ys;
      xs = longint'(coord_type'(x));
      ys = longint'(coord_type'(y));
      case (op)
         OP_CLEAR: begin
            path_len = 0;
         end
         OP_APPEND: begin
            if (path_len < MAX_WAYPOINTS) begin
               path_x[path_len] = xs;
               path_y[path_len] = ys;
               path_len++;
            end
         end
         OP_TEST: begin
            expected_results.insert(expected_results.size(), predict_proximity(xs, ys));
         end
         default: begin
         end
      endcase
   endfunction

   function automatic longint rand_coord();
      coord_type c;
      c = coord_type'($urandom());
      return longint'(c);
   endfunction

   function automatic longint rand_offset(longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   task automatic send_request(input logic [1:0] op, input longint x, input longint y);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {coord_type'(y), coord_type'(x)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(op, x, y);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input int width, input int stride);
      csr_wen <= 1'b1;
      csr_index <= CSR_PATH_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(width);
      @(posedge clock);
      csr_index <= CSR_STRIDE;
      csr_wdata <= CSR_DATA_BITS'(stride & 31);
      @(posedge clock);
      csr_wen <= 1'b0;
      cur_width = width & 32'h7FFF;
      cur_stride = stride & 31;
      settings_written++;
   endtask

   task automatic append_walk(input int n_wp, input longint scale);
      longint x, y;
      x = rand_coord();
      y = rand_coord();
      repeat (n_wp) begin
         send_request(OP_APPEND, x, y);
         if ($urandom_range(0, 9) != 0) begin
            x = clamp_coord(x + rand_offset(scale));
            y = clamp_coord(y + rand_offset(scale));
         end
      end
   endtask

   // Picks a point close to a usable segment; anywhere when there is no path, and one time in eight.
   task automatic near_point(output longint x, output longint y);
      int walk, i, j, t;
      longint margin;
      walk = (cur_stride == 0) ? 1 : cur_stride;
      margin = 2 * longint'(cur_width) + 4;
      if (path_len == 0 || $urandom_range(0, 7) == 0) begin
         x = rand_coord();
         y = rand_coord();
      end else begin
         i = walk * $urandom_range(0, (path_len - 1) / walk);
         j = (i + walk < path_len) ? i + walk : i;
         t = $urandom_range(0, 8);
         x = clamp_coord(path_x[i] + (path_x[j] - path_x[i]) * t / 8 + rand_offset(margin));
         y = clamp_coord(path_y[i] + (path_y[j] - path_y[i]) * t / 8 + rand_offset(margin));
      end
   endtask

   task automatic send_tests(input int count);
      longint x, y;
      repeat (count) begin
         near_point(x, y);
         send_request(OP_TEST, x, y);
      end
   endtask

   task automatic test_empty_and_unused();
      send_request(OP_TEST, 0, 0);
      send_request(OP_UNUSED, COORD_MIN, COORD_MAX);
      send_request(OP_APPEND, 100, -100);
      send_request(OP_TEST, 100, -100);
   endtask

   // Reset settings: path width 512, stride 4, so waypoints 0, 4 and 8 form two segments.
   task automatic test_segment_geometry();
      send_request(OP_CLEAR, 0, 0);
      send_request(OP_APPEND, 0, 0);
      send_request(OP_APPEND, 1, 1);
      send_request(OP_APPEND, 2, 2);
      send_request(OP_APPEND, 3, 3);
      send_request(OP_APPEND, 4096, 0);
      send_request(OP_APPEND, 5, 5);
      send_request(OP_APPEND, 6, 6);
      send_request(OP_APPEND, 7, 7);
      send_request(OP_APPEND, 4096, 4096);
      send_request(OP_TEST, 2048, 511);
      send_request(OP_TEST, 2048, 512);
      send_request(OP_TEST, -511, 0);
      send_request(OP_TEST, 4607, 2000);
      send_request(OP_TEST, 4096, 4696);
   endtask

   // The first segment has zero length, the second spans the whole coordinate range.
   task automatic test_extreme_coordinates();
      wait_idle();
      write_settings(16384, 1);
      send_request(OP_CLEAR, COORD_MAX, COORD_MIN);
      send_request(OP_APPEND, COORD_MIN, COORD_MIN);
      send_request(OP_APPEND, COORD_MIN, COORD_MIN);
      send_request(OP_APPEND, COORD_MAX, COORD_MAX);
      send_request(OP_TEST, 0, 0);
      send_request(OP_TEST, COORD_MAX, COORD_MIN);
      send_request(OP_TEST, COORD_MIN, COORD_MAX);
   endtask

   // Overfills the waypoint store, then walks the same full path at two strides.
   task automatic test_full_path();
      wait_idle();
      write_settings(2048, 1);
      send_request(OP_CLEAR, 0, 0);
      append_walk(MAX_WAYPOINTS + 4, 3000);
      send_tests(8);
      wait_idle();
      write_settings(4096, 31);
      send_tests(6);
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      write_settings(1024, 2);
      send_request(OP_CLEAR, 0, 0);
      append_walk(12, 2500);
      stall_requests++;
      send_tests(20);
      wait_idle();
   endtask

   task automatic test_random_paths(input int phase_no, input int item_budget);
      int stop_at, kind, n_wp, width, stride;
      longint scale;
      stop_at = items_sent + item_budget;
      case (phase_no)
         0: width = 0;
         1: width = 16384;
         2: width = 1;
         3: width = 32767;
         default: width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                       : $urandom_range(64, 4096);
      endcase
      case (phase_no)
         0: stride = 0;
         1: stride = 31;
         2: stride = 16;
         3: stride = 1;
         default: stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 8);
      endcase
      wait_idle();
      write_settings(width, stride);
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 4))
               send_request(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
         end else begin
            if (kind != 1) send_request(OP_CLEAR, rand_coord(), rand_coord());
            n_wp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            scale = (kind == 2) ? 64'd8388608
                                : (longint'(cur_width) + 1) * $urandom_range(1, 8);
            append_walk(n_wp, scale);
            send_tests($urandom_range(2, 10));
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      prox_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: hit %0b segment %0d", $time, rsp_tdata[0],
                     rsp_tdata[SEG_BITS:1]);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[0] !== want.hit) begin
               $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit,
                        rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[SEG_BITS:1] !== want.seg_num) begin
               $display("%0t: segment mismatch: expected %0d, actual %0d", $time,
                        want.seg_num, rsp_tdata[SEG_BITS:1]);
               errors++;
            end
            results_checked++;
            if (want.hit) hits_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         rsp_left <= 400;
         rsp_tready <= 1'b0;
      end else if (rsp_left != 0) begin
         rsp_left <= rsp_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                  quiet_cycles, expected_results.size());
         $display("[point_path_proximity_test] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_no;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_unused();
      test_segment_geometry();
      test_extreme_coordinates();
      test_full_path();
      test_output_backpressure();
      phase_no = 0;
      while (items_sent < ITEM_TARGET - 200) begin
         test_random_paths(phase_no, 140);
         phase_no++;
      end
      gaps_on = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         test_random_paths(phase_no, 100);
         phase_no++;
      end
      wait_idle();
      $display("Sent %0d requests over %0d register settings.", items_sent, settings_written);
      $display("Checked %0d proximity results, %0d of them hits.", results_checked, hits_seen);
      if (errors == 0) begin
         $display("[point_path_proximity_test] OK");
      end else begin
         $display("[point_path_proximity_test] ERROR");
      end
      $finish;
   end

endmodule
